/* sv/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int DATA_W        = 16;

	// one 3x3 matrix per transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] m00;
		logic signed [DATA_W-1:0] m01;
		logic signed [DATA_W-1:0] m02;
		logic signed [DATA_W-1:0] m10;
		logic signed [DATA_W-1:0] m11;
		logic signed [DATA_W-1:0] m12;
		logic signed [DATA_W-1:0] m20;
		logic signed [DATA_W-1:0] m21;
		logic signed [DATA_W-1:0] m22;
	} mat_t;

	// one unit quaternion per transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] qw;
		logic signed [DATA_W-1:0] qx;
		logic signed [DATA_W-1:0] qy;
		logic signed [DATA_W-1:0] qz;
	} quat_t;

	// component index, lower index wins ties
	typedef enum logic [1:0] {
		COMP_W = 2'd0,
		COMP_X = 2'd1,
		COMP_Y = 2'd2,
		COMP_Z = 2'd3
	} comp_t;

	// non-negative flags of the off-diagonal differences and sums
	typedef struct packed {
		logic d21m12;
		logic d02m20;
		logic d10m01;
		logic s10p01;
		logic s02p20;
		logic s21p12;
	} sign_src_t;

endpackage

/* sv/rmq_mat_if.sv */
// ----------------------------------------------------------------------------
// rmq_mat_if
// valid/ready channel carrying one rotation matrix
// ----------------------------------------------------------------------------
interface rmq_mat_if;
	import rmq_pkg::*;

	logic valid;
	logic ready;
	mat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/rmq_quat_if.sv */
// ----------------------------------------------------------------------------
// rmq_quat_if
// valid/ready channel carrying one quaternion
// ----------------------------------------------------------------------------
interface rmq_quat_if;
	import rmq_pkg::*;

	logic  valid;
	logic  ready;
	quat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/rmq_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// pipelined integer square root, one result bit per stage, several lanes
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
	parameter int XW = 33,
	parameter int L  = 4,
	parameter int PW = 6,
	localparam int RW = (XW + 1) / 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [L-1:0][XW-1:0]   in_x,
	input  logic [PW-1:0]          in_pay,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [L-1:0][RW-1:0]   out_root,
	output logic [PW-1:0]          out_pay
);
	localparam int WW = XW + 1;

	logic [WW-1:0] x_s [RW][L];
	logic [WW-1:0] r_s [RW][L];
	logic [PW-1:0] p_s [RW];
	logic          v_s [RW];
	logic [RW:0]   en;

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		en[RW] = out_ready;
		for (int k = RW - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[RW-1];
	assign out_pay   = p_s[RW-1];

	for (genvar l = 0; l < L; l++) begin : g_out
		assign out_root[l] = r_s[RW-1][l][RW-1:0];
	end

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [WW-1:0] BIT = WW'(1) << (2 * (RW - 1 - k));

		logic [WW-1:0] xi [L];
		logic [WW-1:0] ri [L];
		logic [WW-1:0] xo [L];
		logic [WW-1:0] ro [L];
		logic [WW-1:0] tr [L];
		logic [PW-1:0] pi;
		logic          vi;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < L; l++) begin
					xi[l] = WW'(in_x[l]);
					ri[l] = '0;
				end
				pi = in_pay;
				vi = in_valid;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < L; l++) begin
					xi[l] = x_s[k-1][l];
					ri[l] = r_s[k-1][l];
				end
				pi = p_s[k-1];
				vi = v_s[k-1];
			end
		end

		// one digit of the restoring square root
		always_comb begin
			for (int l = 0; l < L; l++) begin
				tr[l] = ri[l] + BIT;
				if (xi[l] >= tr[l]) begin
					xo[l] = xi[l] - tr[l];
					ro[l] = (ri[l] >> 1) + BIT;
				end else begin
					xo[l] = xi[l];
					ro[l] = ri[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				for (int l = 0; l < L; l++) begin
					x_s[k][l] <= xo[l];
					r_s[k][l] <= ro[l];
				end
				p_s[k] <= pi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vi;
			end
		end
	end

endmodule

/* sv/rmq_div_pipe.sv */
// ----------------------------------------------------------------------------
// rmq_div_pipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
	parameter int NW = 33,
	parameter int DW = 18,
	parameter int QW = 15,
	parameter int L  = 4,
	parameter int PW = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [L-1:0][NW-1:0]   in_num,
	input  logic [DW-1:0]          in_den,
	input  logic [PW-1:0]          in_pay,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [L-1:0][QW-1:0]   out_quo,
	output logic [PW-1:0]          out_pay
);
	// the caller keeps num below den * 2^QW, so the remainder fits DW bits
	logic [DW-1:0] rem_s [QW][L];
	logic [QW-1:0] quo_s [QW][L];
	logic [NW-1:0] num_s [QW][L];
	logic [DW-1:0] den_s [QW];
	logic [PW-1:0] p_s   [QW];
	logic          v_s   [QW];
	logic [QW:0]   en;

	always_comb begin
		en[QW] = out_ready;
		for (int k = QW - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[QW-1];
	assign out_pay   = p_s[QW-1];

	for (genvar l = 0; l < L; l++) begin : g_out
		assign out_quo[l] = quo_s[QW-1][l];
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int J = QW - 1 - k;

		logic [DW-1:0] ri [L];
		logic [QW-1:0] qi [L];
		logic [NW-1:0] ni [L];
		logic [DW-1:0] di;
		logic [PW-1:0] pi;
		logic          vi;
		logic [DW:0]   tt [L];
		logic [DW-1:0] ro [L];
		logic [QW-1:0] qo [L];

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < L; l++) begin
					ri[l] = DW'(in_num[l] >> QW);
					qi[l] = '0;
					ni[l] = in_num[l];
				end
				di = in_den;
				pi = in_pay;
				vi = in_valid;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < L; l++) begin
					ri[l] = rem_s[k-1][l];
					qi[l] = quo_s[k-1][l];
					ni[l] = num_s[k-1][l];
				end
				di = den_s[k-1];
				pi = p_s[k-1];
				vi = v_s[k-1];
			end
		end

		// shift in the next dividend bit, subtract when it fits
		always_comb begin
			for (int l = 0; l < L; l++) begin
				tt[l] = {ri[l], ni[l][J]};
				qo[l] = qi[l];
				if (tt[l] >= {1'b0, di}) begin
					ro[l]    = DW'(tt[l] - {1'b0, di});
					qo[l][J] = 1'b1;
				end else begin
					ro[l] = tt[l][DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				for (int l = 0; l < L; l++) begin
					rem_s[k][l] <= ro[l];
					quo_s[k][l] <= qo[l];
					num_s[k][l] <= ni[l];
				end
				den_s[k] <= di;
				p_s[k]   <= pi;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vi;
			end
		end
	end

endmodule

/* sv/rotation_matrix_to_quaternion_top.sv */
// pipeline: the divider plus three single stages (s2, s3, s4) plus both root
//   pipelines, whose depth the word widths set
// throughput: one matrix per cycle while quat.ready is high; every stage of the roots
//   and the divider is its own register stage and a stall only holds full stages
// reset: arst_n clears all valid bits at once; data registers are not reset
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// converts a fixed-point rotation matrix to a normalized unit quaternion
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rmq_mat_if.sink           mat,
	rmq_quat_if.source        quat
);
	import rmq_pkg::*;

	// word widths, all following from FRAC_BITS
	localparam int SW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3; // diagonal sum, signed
	localparam int TW   = SW - 1 + FRAC_BITS;                      // root operand
	localparam int AW   = (TW + 1) / 2;                            // component magnitude
	localparam int NW   = 2 * AW + 2;                              // sum of squares
	localparam int NRW  = (NW + 1) / 2;                            // norm
	localparam int NUMW = AW + FRAC_BITS + 2;                      // dividend
	localparam int QW   = FRAC_BITS + 1;                           // quotient, up to 1.0
	localparam int RCW  = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
	localparam int SPW  = $bits(sign_src_t);
	localparam int P2W  = 4 + 4 * AW;

	localparam logic signed [SW-1:0]  ONE  = SW'(1) << FRAC_BITS;
	localparam logic [QW-1:0]         LIM  = QW'(1) << FRAC_BITS;
	localparam logic signed [RCW-1:0] PMAX = RCW'(32767);
	localparam logic signed [RCW-1:0] NMIN = -RCW'(32768);

	// ------------------------------------------------------------------
	// front: diagonal combinations, clamp, scale; sign sources
	// ------------------------------------------------------------------
	logic signed [SW-1:0]  e00, e11, e22;
	logic signed [SW-1:0]  sdg [4];
	logic [3:0][TW-1:0]    x_in;
	sign_src_t             ssrc_in;
	logic signed [16:0]    d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;

	always_comb begin
		e00 = SW'(mat.data.m00);
		e11 = SW'(mat.data.m11);
		e22 = SW'(mat.data.m22);
		sdg[0] =  e00 + e11 + e22 + ONE;
		sdg[1] =  e00 - e11 - e22 + ONE;
		sdg[2] = -e00 + e11 - e22 + ONE;
		sdg[3] = -e00 - e11 + e22 + ONE;
		// negatives clamp to zero, then scale so the root lands on 2^(F+1)
		for (int i = 0; i < 4; i++) begin
			if (sdg[i][SW-1]) begin
				x_in[i] = '0;
			end else begin
				x_in[i] = TW'(sdg[i][SW-2:0]) << FRAC_BITS;
			end
		end
	end

	// off-diagonal pairs in 17 bits, only the sign is kept (zero counts positive)
	assign d21m12 = 17'(mat.data.m21) - 17'(mat.data.m12);
	assign d02m20 = 17'(mat.data.m02) - 17'(mat.data.m20);
	assign d10m01 = 17'(mat.data.m10) - 17'(mat.data.m01);
	assign s10p01 = 17'(mat.data.m10) + 17'(mat.data.m01);
	assign s02p20 = 17'(mat.data.m02) + 17'(mat.data.m20);
	assign s21p12 = 17'(mat.data.m21) + 17'(mat.data.m12);

	always_comb begin
		ssrc_in.d21m12 = !d21m12[16];
		ssrc_in.d02m20 = !d02m20[16];
		ssrc_in.d10m01 = !d10m01[16];
		ssrc_in.s10p01 = !s10p01[16];
		ssrc_in.s02p20 = !s02p20[16];
		ssrc_in.s21p12 = !s21p12[16];
	end

	// ------------------------------------------------------------------
	// component magnitudes: four-lane square root
	// ------------------------------------------------------------------
	logic               sq1_out_valid;
	logic [3:0][AW-1:0] a_root;
	logic [SPW-1:0]     sq1_out_pay;
	logic               en2, en3, en4;

	rmq_sqrt_pipe #(
		.XW (TW),
		.L  (4),
		.PW (SPW)
	) u_sqrt_comp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat.valid),
		.in_ready  (mat.ready),
		.in_x      (x_in),
		.in_pay    (ssrc_in),
		.out_valid (sq1_out_valid),
		.out_ready (en2),
		.out_root  (a_root),
		.out_pay   (sq1_out_pay)
	);

	// ------------------------------------------------------------------
	// s2: squares
	// ------------------------------------------------------------------
	logic                 v_s2;
	logic [3:0][AW-1:0]   a_s2;
	logic [3:0][2*AW-1:0] sq_s2;
	sign_src_t            ssrc_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 4; i++) begin
				a_s2[i]  <= a_root[i];
				sq_s2[i] <= a_root[i] * a_root[i];
			end
			ssrc_s2 <= sq1_out_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= sq1_out_valid;
		end
	end

	// ------------------------------------------------------------------
	// s3: sum of squares, largest component, final signs
	// ------------------------------------------------------------------
	logic               v_s3;
	logic [NW-1:0]      n2_s3;
	logic [3:0][AW-1:0] a_s3;
	logic [3:0]         sg_s3;
	comp_t              best;
	logic [3:0]         sg_nxt;

	// strict compare, so a tie keeps the lower index
	always_comb begin
		best = COMP_W;
		if (a_s2[1] > a_s2[best]) best = COMP_X;
		if (a_s2[2] > a_s2[best]) best = COMP_Y;
		if (a_s2[3] > a_s2[best]) best = COMP_Z;
	end

	// sign bit set means non-negative; order w, x, y, z in bits 0..3
	always_comb begin
		case (best)
			COMP_W:  sg_nxt = {ssrc_s2.d10m01, ssrc_s2.d02m20, ssrc_s2.d21m12, 1'b1};
			COMP_X:  sg_nxt = {ssrc_s2.s02p20, ssrc_s2.s10p01, 1'b1, ssrc_s2.d21m12};
			COMP_Y:  sg_nxt = {ssrc_s2.s21p12, 1'b1, ssrc_s2.s10p01, ssrc_s2.d02m20};
			COMP_Z:  sg_nxt = {1'b1, ssrc_s2.s21p12, ssrc_s2.s02p20, ssrc_s2.d10m01};
			default: sg_nxt = 4'b1111;
		endcase
	end

	logic               sq2_in_ready;

	always_ff @(posedge clk) begin
		if (en3) begin
			n2_s3 <= NW'(sq_s2[0]) + NW'(sq_s2[1]) + NW'(sq_s2[2]) + NW'(sq_s2[3]);
			a_s3  <= a_s2;
			sg_s3 <= sg_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	// ------------------------------------------------------------------
	// norm: single-lane square root, magnitudes and signs ride along
	// ------------------------------------------------------------------
	logic [0:0][NW-1:0]  n2_lane;
	logic [0:0][NRW-1:0] nrm_lane;
	logic [P2W-1:0]      sq2_out_pay;
	logic                sq2_out_valid;
	logic                div_in_ready;
	logic [NRW-1:0]      nrm;
	logic [3:0][AW-1:0]  a_nrm;
	logic [3:0]          sg_nrm;

	assign n2_lane[0] = n2_s3;

	rmq_sqrt_pipe #(
		.XW (NW),
		.L  (1),
		.PW (P2W)
	) u_sqrt_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (sq2_in_ready),
		.in_x      (n2_lane),
		.in_pay    ({sg_s3, a_s3}),
		.out_valid (sq2_out_valid),
		.out_ready (div_in_ready),
		.out_root  (nrm_lane),
		.out_pay   (sq2_out_pay)
	);

	assign nrm    = nrm_lane[0];
	assign a_nrm  = sq2_out_pay[4*AW-1:0];
	assign sg_nrm = sq2_out_pay[P2W-1:4*AW];

	// ------------------------------------------------------------------
	// normalize: (a * 2^F + nrm/2) / nrm, halves round up
	// ------------------------------------------------------------------
	logic [3:0][NUMW-1:0] num;
	logic                 div_out_valid;
	logic [3:0][QW-1:0]   quo;
	logic [3:0]           sg_div;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num[i] = (NUMW'(a_nrm[i]) << FRAC_BITS) + NUMW'(nrm >> 1);
		end
	end

	rmq_div_pipe #(
		.NW (NUMW),
		.DW (NRW),
		.QW (QW),
		.L  (4),
		.PW (4)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq2_out_valid),
		.in_ready  (div_in_ready),
		.in_num    (num),
		.in_den    (nrm),
		.in_pay    (sg_nrm),
		.out_valid (div_out_valid),
		.out_ready (en4),
		.out_quo   (quo),
		.out_pay   (sg_div)
	);

	// ------------------------------------------------------------------
	// s4: limit to 1.0, apply sign, clamp to 16 bits; output register
	// ------------------------------------------------------------------
	logic                  v_s4;
	quat_t                 q_s4;
	logic [QW-1:0]         mag  [4];
	logic signed [RCW-1:0] sval [4];
	logic [3:0][DATA_W-1:0] qv;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i]  = (quo[i] > LIM) ? LIM : quo[i];
			sval[i] = sg_div[i] ? RCW'(mag[i]) : -RCW'(mag[i]);
			if (sval[i] > PMAX) begin
				sval[i] = PMAX;
			end else if (sval[i] < NMIN) begin
				sval[i] = NMIN;
			end
			qv[i] = sval[i][DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			q_s4.qw <= qv[0];
			q_s4.qx <= qv[1];
			q_s4.qy <= qv[2];
			q_s4.qz <= qv[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= div_out_valid;
		end
	end

	// a full stage holds while the one after it cannot take its transaction
	assign en4 = !v_s4 || quat.ready;
	assign en3 = !v_s3 || sq2_in_ready;
	assign en2 = !v_s2 || en3;

	assign quat.valid = v_s4;
	assign quat.data  = q_s4;

`ifndef ASSERT_OFF
	localparam int OUT_LIM = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;

	// the largest component is always marked non-negative, so some sign bit is set
	a_best_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sg_s3 != 4'b0000))
		else $error("no component marked non-negative");

	// the four diagonal sums add to four, so the norm is never zero
	a_norm_nz: assert property (@(posedge clk) disable iff (!arst_n)
		sq2_out_valid |-> (nrm != '0))
		else $error("zero norm reached the divider");

	// a stalled stage keeps its sum
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en3) |=> (v_s3 && $stable(n2_s3)))
		else $error("stage 3 lost or changed a stalled transaction");

	// normalized output stays within plus or minus one
	a_out_rng: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (int'(q_s4.qw) <= OUT_LIM && int'(q_s4.qw) >= -OUT_LIM &&
			int'(q_s4.qx) <= OUT_LIM && int'(q_s4.qx) >= -OUT_LIM &&
			int'(q_s4.qy) <= OUT_LIM && int'(q_s4.qy) >= -OUT_LIM &&
			int'(q_s4.qz) <= OUT_LIM && int'(q_s4.qz) >= -OUT_LIM))
		else $error("quaternion component out of range");
`endif

endmodule

/* tb/tb_rotation_matrix_to_quaternion_top.sv */
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// drives fixed-point matrices through the converter, predicts each quaternion
// with a bit-accurate model and compares every output transaction in order
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
	import rmq_pkg::*;

	localparam int FB        = FRAC_BITS_DEF;
	localparam int LATENCY   = 2 * FB + 40;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1830;

	logic clk;
	logic arst_n;

	rmq_mat_if  mat ();
	rmq_quat_if quat ();

	rotation_matrix_to_quaternion_top #(.FRAC_BITS(FB)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat),
		.quat   (quat)
	);

	// pending matrices for the driver, expected quaternions for the monitor
	mat_t  mat_pending[$];
	quat_t quat_expected[$];

	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int          n_errors;
	int          wdog;

	// integer square root, floor
	function automatic longint unsigned isqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// limit magnitude to one, apply sign (zero counts as positive), fit 16 bits
	function automatic logic signed [DATA_W-1:0] signed_mag(input longint sgn,
			input longint unsigned mag);
		longint r;
		r = (mag > (64'd1 << FB)) ? (longint'(1) << FB) : longint'(mag);
		if (sgn < 0)
			r = -r;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[DATA_W-1:0];
	endfunction

	function automatic quat_t matrix_to_quat(input mat_t m);
		longint          e00, e01, e02, e10, e11, e12, e20, e21, e22;
		longint          one;
		longint          comb[4];
		longint          sgn[4];
		longint unsigned mag[4];
		longint unsigned n2;
		longint unsigned nrm;
		longint unsigned q;
		comp_t           big;
		quat_t           r;
		logic signed [DATA_W-1:0] o[4];
		e00 = m.m00; e01 = m.m01; e02 = m.m02;
		e10 = m.m10; e11 = m.m11; e12 = m.m12;
		e20 = m.m20; e21 = m.m21; e22 = m.m22;
		one = longint'(1) << FB;
		comb[0] = e00 + e11 + e22 + one;
		comb[1] = e00 - e11 - e22 + one;
		comb[2] = -e00 + e11 - e22 + one;
		comb[3] = -e00 - e11 + e22 + one;
		n2 = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = isqrt((comb[i] < 0 ? 64'd0 : longint'(comb[i])) << FB);
			n2 += mag[i] * mag[i];
		end
		// strict compare keeps the lower index on ties
		big = COMP_W;
		for (int i = 1; i < 4; i++)
			if (mag[i] > mag[big])
				big = comp_t'(i);
		case (big)
			COMP_W: begin
				sgn[0] = 1; sgn[1] = e21 - e12; sgn[2] = e02 - e20; sgn[3] = e10 - e01;
			end
			COMP_X: begin
				sgn[0] = e21 - e12; sgn[1] = 1; sgn[2] = e10 + e01; sgn[3] = e02 + e20;
			end
			COMP_Y: begin
				sgn[0] = e02 - e20; sgn[1] = e10 + e01; sgn[2] = 1; sgn[3] = e21 + e12;
			end
			default: begin
				sgn[0] = e10 - e01; sgn[1] = e20 + e02; sgn[2] = e21 + e12; sgn[3] = 1;
			end
		endcase
		nrm = isqrt(n2);
		for (int i = 0; i < 4; i++) begin
			q = (nrm != 0) ? ((mag[i] << FB) + (nrm >> 1)) / nrm : 0;
			o[i] = signed_mag(sgn[i], q);
		end
		r.qw = o[0]; r.qx = o[1]; r.qy = o[2]; r.qz = o[3];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_elem();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return DATA_W'($urandom());        // any bit pattern
		if (k == 1)
			return (($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384);
		return DATA_W'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic mat_t rand_mat();
		mat_t m;
		int unsigned k;
		logic signed [DATA_W-1:0] one;
		one = 16'sd1 << FB;
		m = '{default: 0};
		m.m00 = rand_elem(); m.m01 = rand_elem(); m.m02 = rand_elem();
		m.m10 = rand_elem(); m.m11 = rand_elem(); m.m12 = rand_elem();
		m.m20 = rand_elem(); m.m21 = rand_elem(); m.m22 = rand_elem();
		k = $urandom_range(0, 5);
		// half-turns about x and y make those components the largest, equal diagonals force ties
		if (k == 1) begin
			m.m00 = one; m.m11 = -one; m.m22 = -one;
		end else if (k == 2) begin
			m.m00 = -one; m.m11 = one; m.m22 = -one;
		end else if (k == 3) begin
			m.m00 = m.m11; m.m22 = m.m11;
		end else if (k == 4) begin
			m.m01 = m.m10; m.m02 = m.m20; m.m12 = m.m21;
		end
		return m;
	endfunction

	task automatic push_mat(input mat_t m);
		mat_pending.push_back(m);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stimulus and end of run
	initial begin
		mat_t m;
		logic signed [DATA_W-1:0] one;
		one = 16'sd1 << FB;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: identity, half-turns about each axis, extremes, ties, zero
		m = '{default: 0}; m.m00 = one; m.m11 = one; m.m22 = one; push_mat(m);
		m = '{default: 0}; m.m00 = one; m.m11 = -one; m.m22 = -one; push_mat(m);
		m = '{default: 0}; m.m00 = -one; m.m11 = one; m.m22 = -one; push_mat(m);
		m = '{default: 0}; m.m00 = -one; m.m11 = -one; m.m22 = one; push_mat(m);
		m = '{default: 0}; push_mat(m);
		m = '{default: one}; push_mat(m);
		m = '{default: -one}; push_mat(m);
		m = '{default: 16'sh7fff}; push_mat(m);
		m = '{default: 16'sh8000}; push_mat(m);
		m = '{default: 16'shffff}; push_mat(m);
		m = '{default: 16'sh5555}; push_mat(m);
		m = '{default: 16'shaaaa}; push_mat(m);
		// quarter turn about z: w and z tie, sign from m10-m01
		m = '{default: 0}; m.m01 = -one; m.m10 = one; m.m22 = one; push_mat(m);
		m = '{default: 0}; m.m01 = one; m.m10 = -one; m.m22 = one; push_mat(m);
		// quarter turn about x and y
		m = '{default: 0}; m.m00 = one; m.m12 = -one; m.m21 = one; push_mat(m);
		m = '{default: 0}; m.m11 = one; m.m02 = one; m.m20 = -one; push_mat(m);
		// off-diagonal difference exactly zero, then just below zero
		m = '{default: 0}; m.m00 = one; m.m01 = 100; m.m10 = 100; m.m11 = -one;
		m.m22 = -one; push_mat(m);
		m = '{default: 0}; m.m00 = one; m.m11 = one; m.m22 = one;
		m.m12 = 5; m.m21 = 4; push_mat(m);

		// random, phase by phase with different idle/stall pressure
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < N_RANDOM / 4; i++)
				push_mat(rand_mat());
			wait (mat_pending.size() == 0);
			@(posedge clk);
			src_idle_pct  = (ph == 0) ? 87 : (ph == 1) ? 0 : 24;
			snk_stall_pct = (ph == 0) ? 0 : (ph == 1) ? 87 : 24;
		end
		wait (mat_pending.size() == 0 && quat_expected.size() == 0);
		repeat (LATENCY) @(posedge clk);
		if (n_errors == 0 && quat_expected.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.valid <= 1'b0;
			mat.data  <= '0;
		end else begin
			if (mat.valid && mat.ready) begin
				quat_expected.push_back(matrix_to_quat(mat.data));
				void'(mat_pending.pop_front());
			end
			// next item is the queue head once the current one is gone
			if (!mat.valid || mat.ready) begin
				if ((mat.valid && mat.ready ? mat_pending.size() > 0 :
						mat_pending.size() > 0) &&
						$urandom_range(0, 99) >= src_idle_pct) begin
					mat.valid <= 1'b1;
					mat.data  <= mat_pending[0];
				end else begin
					mat.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		quat_t exp_q;
		if (!arst_n) begin
			quat.ready <= 1'b0;
			n_errors   <= 0;
			wdog       <= 0;
		end else begin
			quat.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			if ((mat.valid && mat.ready) || (quat.valid && quat.ready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("simulation failed");
				$finish;
			end
			if (quat.valid && quat.ready) begin
				if (quat_expected.size() == 0) begin
					if (n_errors < 10)
						$display("unexpected quaternion transaction: %p", quat.data);
					n_errors <= n_errors + 1;
				end else begin
					exp_q = quat_expected.pop_front();
					if (quat.data !== exp_q) begin
						if (n_errors < 10)
							$display("mismatch qw/qx/qy/qz exp %0d %0d %0d %0d got %0d %0d %0d %0d",
								exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz,
								quat.data.qw, quat.data.qx, quat.data.qy, quat.data.qz);
						n_errors <= n_errors + 1;
					end
				end
			end
		end
	end

	// inputs known from time zero
	initial begin
		mat.valid  = 1'b0;
		mat.data   = '0;
		quat.ready = 1'b0;
	end

endmodule

/* filelist.f */
sv/rmq_pkg.sv
sv/rmq_mat_if.sv
sv/rmq_quat_if.sv
sv/rmq_sqrt_pipe.sv
sv/rmq_div_pipe.sv
sv/rotation_matrix_to_quaternion_top.sv
tb/tb_rotation_matrix_to_quaternion_top.sv
